### rtl/core/frac_pkg.sv
// Shared types and constants of the fusion ring axiom checker.
package frac_pkg;

  localparam int unsigned COEFF_FIELD_W = 20;
  localparam int unsigned RANK_FIELD_W  = 6;
  localparam int unsigned IN_DATA_W     = 32;
  localparam int unsigned OUT_DATA_W    = 24;
  localparam int unsigned FAIL_W        = 5;
  localparam int unsigned SUM_W         = 48;
  localparam int unsigned COUNT_W       = 16;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_UNIT    = 3'd1,
    ST_DUAL    = 3'd2,
    ST_MISSING = 3'd3,
    ST_INVOL   = 3'd4,
    ST_RECIP   = 3'd5,
    ST_ASSOC   = 3'd6,
    ST_COUNT   = 3'd7
  } status_e;

  typedef enum logic [22:0] {
    S_LOAD = 23'd1 << 0,
    S_CHK0 = 23'd1 << 1,
    S_CHK1 = 23'd1 << 2,
    S_CHK2 = 23'd1 << 3,
    S_UA   = 23'd1 << 4,
    S_UB   = 23'd1 << 5,
    S_UC   = 23'd1 << 6,
    S_UD   = 23'd1 << 7,
    S_MISS = 23'd1 << 8,
    S_VA   = 23'd1 << 9,
    S_VB   = 23'd1 << 10,
    S_RA   = 23'd1 << 11,
    S_RB   = 23'd1 << 12,
    S_RC   = 23'd1 << 13,
    S_RD   = 23'd1 << 14,
    S_A1   = 23'd1 << 15,
    S_A2   = 23'd1 << 16,
    S_A3   = 23'd1 << 17,
    S_A4   = 23'd1 << 18,
    S_A5   = 23'd1 << 19,
    S_A6   = 23'd1 << 20,
    S_ACMP = 23'd1 << 21,
    S_DONE = 23'd1 << 22
  } state_e;

  typedef struct packed {
    logic clear;
    logic mul;
    logic acc_left;
    logic acc_right;
  } mac_ctrl_t;

endpackage

### rtl/core/frac_ram.sv
// Generic single-write, single-read RAM with registered read data.
module frac_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/frac_mac.sv
// Shared multiplier with the left and right product-sum accumulators.
module frac_mac
  import frac_pkg::*;
#(
  parameter int unsigned CoeffBits = 20
) (
  input  logic                 clk_i,
  input  mac_ctrl_t            ctrl_i,
  input  logic [CoeffBits-1:0] a_i,
  input  logic [CoeffBits-1:0] b_i,
  output logic                 eq_o
);

  logic [2*CoeffBits-1:0] prod_q;
  logic [SUM_W-1:0]       left_q;
  logic [SUM_W-1:0]       right_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      prod_q <= (2*CoeffBits)'(a_i) * (2*CoeffBits)'(b_i);
    end
    if (ctrl_i.clear) begin
      left_q  <= '0;
      right_q <= '0;
    end else begin
      if (ctrl_i.acc_left) begin
        left_q <= left_q + SUM_W'(prod_q);
      end
      if (ctrl_i.acc_right) begin
        right_q <= right_q + SUM_W'(prod_q);
      end
    end
  end

  assign eq_o = (left_q == right_q);

endmodule

### rtl/core/fusion_ring_axiom_checker.sv
// After the last transfer the checks run in sequence and the result is raised from the
// completion state; a failing check ends the sequence early.
// Throughput: one coefficient per cycle while loading; no input is taken during checking,
// which is paced by the single store read port and the shared multiplier.
// Reset: asynchronous, active low; clears the sequencer, counters, dual valid bits and
// the output valid, and sets the associativity enable to one.
module fusion_ring_axiom_checker
  import frac_pkg::*;
#(
  parameter int unsigned MAX_RANK_P = 32,
  parameter int unsigned COEFF_BITS = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_wr_en_i,
  input  logic                  cfg_wr_data_i,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // coefficient[19:0], rank[25:20], zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic                  s_axis_tlast_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // status[2:0], fail_i[7:3], fail_j[12:8], fail_k[17:13], fail_l[22:18], zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned IdxW  = $clog2(MAX_RANK_P);
  localparam int unsigned CntW  = IdxW + 1;
  localparam int unsigned AddrW = 3 * IdxW;
  localparam int unsigned Depth = 1 << AddrW;
  localparam int unsigned DualN = 1 << IdxW;

  state_e                    state_q, state_d;
  logic [COUNT_W-1:0]        items_q, items_d;
  logic [RANK_FIELD_W-1:0]   rank_q, rank_d;
  logic [CntW-1:0]           lk_q, lk_d, lj_q, lj_d, li_q, li_d;
  logic                      assoc_en_q;
  logic [IdxW-1:0]           i_q, i_d, j_q, j_d, k_q, k_d, l_q, l_d, s_q, s_d;
  logic [IdxW-1:0]           di_q, di_d, dj_q, dj_d;
  logic [COEFF_BITS-1:0]     v_q, v_d;
  logic [11:0]               sq_q, sq_d;
  logic [COUNT_W-1:0]        cube_q, cube_d;
  logic [DualN-1:0]          dset_q, dset_d;
  logic [IdxW-1:0]           dual_q [DualN];
  logic [IdxW-1:0]           dual_d [DualN];
  status_e                   res_status_q, res_status_d;
  logic [IdxW-1:0]           rfi_q, rfi_d, rfj_q, rfj_d, rfk_q, rfk_d, rfl_q, rfl_d;
  logic                      out_valid_q, out_valid_d;
  logic [2:0]                out_status_q, out_status_d;
  logic [FAIL_W-1:0]         ofi_q, ofi_d, ofj_q, ofj_d, ofk_q, ofk_d, ofl_q, ofl_d;

  logic                      s_fire;
  logic [RANK_FIELD_W-1:0]   load_n;
  logic                      load_n_ok;
  logic                      ram_we;
  logic [AddrW-1:0]          ram_waddr, rd_addr;
  logic [COEFF_BITS-1:0]     ram_wdata, rdata, id_val;
  logic [IdxW-1:0]           nm1;
  mac_ctrl_t                 mac_ctrl;
  logic                      mac_eq;

  assign s_axis_tready_o = (state_q == S_LOAD);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign load_n          = (items_q == '0) ? s_axis_tdata_i[25:20] : rank_q;
  assign load_n_ok       = (load_n != '0) && (7'(load_n) <= 7'(MAX_RANK_P));
  assign ram_we          = s_fire && load_n_ok && (7'(li_q) < 7'(load_n));
  assign ram_waddr       = {li_q[IdxW-1:0], lj_q[IdxW-1:0], lk_q[IdxW-1:0]};
  assign ram_wdata       = s_axis_tdata_i[COEFF_BITS-1:0];
  assign nm1             = IdxW'(rank_q - 6'd1);
  assign id_val          = (i_q == j_q) ? COEFF_BITS'(1) : '0;

  frac_ram #(
    .Width (COEFF_BITS),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  frac_mac #(
    .CoeffBits (COEFF_BITS)
  ) u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .a_i    (v_q),
    .b_i    (rdata),
    .eq_o   (mac_eq)
  );

  always_comb begin
    state_d      = state_q;
    items_d      = items_q;
    rank_d       = rank_q;
    lk_d         = lk_q;
    lj_d         = lj_q;
    li_d         = li_q;
    i_d          = i_q;
    j_d          = j_q;
    k_d          = k_q;
    l_d          = l_q;
    s_d          = s_q;
    di_d         = di_q;
    dj_d         = dj_q;
    v_d          = v_q;
    sq_d         = sq_q;
    cube_d       = cube_q;
    dset_d       = dset_q;
    dual_d       = dual_q;
    res_status_d = res_status_q;
    rfi_d        = rfi_q;
    rfj_d        = rfj_q;
    rfk_d        = rfk_q;
    rfl_d        = rfl_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    ofi_d        = ofi_q;
    ofj_d        = ofj_q;
    ofk_d        = ofk_q;
    ofl_d        = ofl_q;
    rd_addr      = '0;
    mac_ctrl     = '0;

    unique case (state_q)
      S_LOAD: begin
        if (s_fire) begin
          if (items_q == '0) begin
            rank_d = s_axis_tdata_i[25:20];
          end
          if (items_q != {COUNT_W{1'b1}}) begin
            items_d = items_q + 1'b1;
          end
          if ((7'(lk_q) + 7'd1) == 7'(load_n)) begin
            lk_d = '0;
            if ((7'(lj_q) + 7'd1) == 7'(load_n)) begin
              lj_d = '0;
              if (7'(li_q) < 7'(load_n)) begin
                li_d = li_q + 1'b1;
              end
            end else begin
              lj_d = lj_q + 1'b1;
            end
          end else begin
            lk_d = lk_q + 1'b1;
          end
          if (s_axis_tlast_i) begin
            state_d = S_CHK0;
          end
        end
      end
      S_CHK0: begin
        rfi_d = '0;
        rfj_d = '0;
        rfk_d = '0;
        rfl_d = '0;
        if ((rank_q == '0) || (7'(rank_q) > 7'(MAX_RANK_P))) begin
          res_status_d = ST_COUNT;
          state_d      = S_DONE;
        end else begin
          sq_d    = 12'(rank_q) * 12'(rank_q);
          state_d = S_CHK1;
        end
      end
      S_CHK1: begin
        cube_d  = COUNT_W'(sq_q) * COUNT_W'(rank_q);
        state_d = S_CHK2;
      end
      S_CHK2: begin
        if (items_q != cube_q) begin
          res_status_d = ST_COUNT;
          state_d      = S_DONE;
        end else begin
          dset_d  = '0;
          i_d     = '0;
          j_d     = '0;
          state_d = S_UA;
        end
      end
      S_UA: begin
        rd_addr = {{IdxW{1'b0}}, i_q, j_q};
        state_d = S_UB;
      end
      S_UB: begin
        if (rdata != id_val) begin
          res_status_d = ST_UNIT;
          state_d      = S_DONE;
        end else begin
          rd_addr = {i_q, {IdxW{1'b0}}, j_q};
          state_d = S_UC;
        end
      end
      S_UC: begin
        if (rdata != id_val) begin
          res_status_d = ST_UNIT;
          state_d      = S_DONE;
        end else begin
          rd_addr = {i_q, j_q, {IdxW{1'b0}}};
          state_d = S_UD;
        end
      end
      S_UD: begin
        if ((rdata != '0) && ((rdata != COEFF_BITS'(1)) || dset_q[i_q])) begin
          res_status_d = ST_DUAL;
          state_d      = S_DONE;
        end else begin
          if (rdata != '0) begin
            dset_d[i_q] = 1'b1;
            dual_d[i_q] = j_q;
          end
          state_d = S_UA;
          if (j_q == nm1) begin
            j_d = '0;
            if (i_q == nm1) begin
              i_d     = '0;
              state_d = S_MISS;
            end else begin
              i_d = i_q + 1'b1;
            end
          end else begin
            j_d = j_q + 1'b1;
          end
        end
      end
      S_MISS: begin
        if (!dset_q[i_q]) begin
          res_status_d = ST_MISSING;
          state_d      = S_DONE;
        end else if (i_q == nm1) begin
          i_d     = '0;
          state_d = S_VA;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      S_VA: begin
        di_d    = dual_q[i_q];
        state_d = S_VB;
      end
      S_VB: begin
        if (dual_q[di_q] != i_q) begin
          res_status_d = ST_INVOL;
          state_d      = S_DONE;
        end else if (i_q == nm1) begin
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
          state_d = S_RA;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_VA;
        end
      end
      S_RA: begin
        di_d    = dual_q[i_q];
        rd_addr = {i_q, j_q, k_q};
        state_d = S_RB;
      end
      S_RB: begin
        dj_d    = dual_q[j_q];
        v_d     = rdata;
        rd_addr = {di_q, k_q, j_q};
        state_d = S_RC;
      end
      S_RC: begin
        if (rdata != v_q) begin
          res_status_d = ST_RECIP;
          state_d      = S_DONE;
        end else begin
          rd_addr = {k_q, dj_q, i_q};
          state_d = S_RD;
        end
      end
      S_RD: begin
        if (rdata != v_q) begin
          res_status_d = ST_RECIP;
          state_d      = S_DONE;
        end else begin
          state_d = S_RA;
          if (k_q == nm1) begin
            k_d = '0;
            if (j_q == nm1) begin
              j_d = '0;
              if (i_q == nm1) begin
                i_d = '0;
                l_d = '0;
                s_d = '0;
                if (assoc_en_q) begin
                  mac_ctrl.clear = 1'b1;
                  state_d        = S_A1;
                end else begin
                  res_status_d = ST_OK;
                  state_d      = S_DONE;
                end
              end else begin
                i_d = i_q + 1'b1;
              end
            end else begin
              j_d = j_q + 1'b1;
            end
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      S_A1: begin
        rd_addr = {i_q, j_q, s_q};
        state_d = S_A2;
      end
      S_A2: begin
        v_d     = rdata;
        rd_addr = {s_q, k_q, l_q};
        state_d = S_A3;
      end
      S_A3: begin
        mac_ctrl.mul = 1'b1;
        rd_addr      = {j_q, k_q, s_q};
        state_d      = S_A4;
      end
      S_A4: begin
        mac_ctrl.acc_left = 1'b1;
        v_d               = rdata;
        rd_addr           = {i_q, s_q, l_q};
        state_d           = S_A5;
      end
      S_A5: begin
        mac_ctrl.mul = 1'b1;
        state_d      = S_A6;
      end
      S_A6: begin
        mac_ctrl.acc_right = 1'b1;
        if (s_q == nm1) begin
          s_d     = '0;
          state_d = S_ACMP;
        end else begin
          s_d     = s_q + 1'b1;
          state_d = S_A1;
        end
      end
      S_ACMP: begin
        if (!mac_eq) begin
          res_status_d = ST_ASSOC;
          rfi_d        = i_q;
          rfj_d        = j_q;
          rfk_d        = k_q;
          rfl_d        = l_q;
          state_d      = S_DONE;
        end else begin
          mac_ctrl.clear = 1'b1;
          state_d        = S_A1;
          if (l_q == nm1) begin
            l_d = '0;
            if (k_q == nm1) begin
              k_d = '0;
              if (j_q == nm1) begin
                j_d = '0;
                if (i_q == nm1) begin
                  i_d          = '0;
                  res_status_d = ST_OK;
                  state_d      = S_DONE;
                end else begin
                  i_d = i_q + 1'b1;
                end
              end else begin
                j_d = j_q + 1'b1;
              end
            end else begin
              k_d = k_q + 1'b1;
            end
          end else begin
            l_d = l_q + 1'b1;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          ofi_d        = FAIL_W'(rfi_q);
          ofj_d        = FAIL_W'(rfj_q);
          ofk_d        = FAIL_W'(rfk_q);
          ofl_d        = FAIL_W'(rfl_q);
          items_d      = '0;
          lk_d         = '0;
          lj_d         = '0;
          li_d         = '0;
          state_d      = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      items_q     <= '0;
      rank_q      <= '0;
      lk_q        <= '0;
      lj_q        <= '0;
      li_q        <= '0;
      assoc_en_q  <= 1'b1;
      dset_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      items_q     <= items_d;
      rank_q      <= rank_d;
      lk_q        <= lk_d;
      lj_q        <= lj_d;
      li_q        <= li_d;
      dset_q      <= dset_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr_en_i) begin
        assoc_en_q <= cfg_wr_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q          <= i_d;
    j_q          <= j_d;
    k_q          <= k_d;
    l_q          <= l_d;
    s_q          <= s_d;
    di_q         <= di_d;
    dj_q         <= dj_d;
    v_q          <= v_d;
    sq_q         <= sq_d;
    cube_q       <= cube_d;
    dual_q       <= dual_d;
    res_status_q <= res_status_d;
    rfi_q        <= rfi_d;
    rfj_q        <= rfj_d;
    rfk_q        <= rfk_d;
    rfl_q        <= rfl_d;
    out_status_q <= out_status_d;
    ofi_q        <= ofi_d;
    ofj_q        <= ofj_d;
    ofk_q        <= ofk_d;
    ofl_q        <= ofl_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, ofl_q, ofk_q, ofj_q, ofi_q, out_status_q};

`ifndef SYNTHESIS
  a_last_stops_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("input still ready after the last coefficient transfer");

  a_fail_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q != ST_ASSOC) |->
      (ofi_q == '0) && (ofj_q == '0) && (ofk_q == '0) && (ofl_q == '0))
    else $error("failure indices set for a status other than associativity");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside the completion state");

  a_count_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) && (!out_valid_q || m_axis_tready_i) |=> (items_q == '0))
    else $error("item count not cleared after a result");
`endif

endmodule

### tb/sv/fusion_ring_axiom_checker_tb.sv
// Self-checking testbench for the fusion ring axiom checker with streamed tensors.
`timescale 1ns / 1ps

module fusion_ring_axiom_checker_tb;
  import frac_pkg::*;

  localparam int unsigned STORE_D = 32 * 32 * 32;
  localparam longint CYCLE_LIMIT = 6000000;

  typedef struct {
    bit [19:0] coeff;
    bit [5:0]  rank;
    bit        last;
  } coeff_item_t;

  typedef struct {
    status_e  st;
    bit [4:0] fi, fj, fk, fl;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_wr_en_i = 1'b0;
  logic cfg_wr_data_i = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [IN_DATA_W-1:0] s_axis_tdata_i = '0;
  logic s_axis_tlast_i = 1'b0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  fusion_ring_axiom_checker uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_wr_en_i(cfg_wr_en_i), .cfg_wr_data_i(cfg_wr_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i), .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(s_axis_tdata_i), .s_axis_tlast_i(s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o), .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o(m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  coeff_item_t pend_q[$];
  verdict_t    verdict_q[$];
  bit [19:0]   tensor_mem [STORE_D];
  int unsigned loaded_cnt = 0;
  int unsigned tensor_rank = 0;
  bit          assoc_en = 1'b1;
  bit          quiet = 1'b0;
  int          errors = 0;
  int          tensors_sent = 0;
  int          status_seen [8];
  longint      cycles = 0;
  int          tx_gap = 0;
  int          rx_gap = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  function automatic bit [19:0] coef_at(int unsigned n, int unsigned i, int unsigned j,
                                        int unsigned k);
    int unsigned addr;
    addr = (i * n + j) * n + k;
    return (addr < STORE_D) ? tensor_mem[addr] : 20'd0;
  endfunction

  function automatic verdict_t judge_tensor();
    verdict_t r;
    int unsigned n;
    bit [5:0] dual [32];
    bit has_dual [32];
    bit [19:0] v, id;
    longint unsigned a, b;
    n = tensor_rank;
    r = '{ST_OK, 0, 0, 0, 0};
    if (n == 0 || n > 32 || loaded_cnt != n * n * n) begin
      r.st = ST_COUNT;
      return r;
    end
    for (int i = 0; i < 32; i++) begin
      dual[i] = 0;
      has_dual[i] = 0;
    end
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        id = (i == j) ? 20'd1 : 20'd0;
        if (coef_at(n, 0, i, j) != id || coef_at(n, i, 0, j) != id) begin
          r.st = ST_UNIT;
          return r;
        end
        v = coef_at(n, i, j, 0);
        if (v != 0) begin
          if (v != 1 || has_dual[i]) begin
            r.st = ST_DUAL;
            return r;
          end
          has_dual[i] = 1;
          dual[i] = j;
        end
      end
    for (int i = 0; i < n; i++)
      if (!has_dual[i]) begin
        r.st = ST_MISSING;
        return r;
      end
    for (int i = 0; i < n; i++)
      if (dual[dual[i]] != i) begin
        r.st = ST_INVOL;
        return r;
      end
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        for (int k = 0; k < n; k++) begin
          v = coef_at(n, i, j, k);
          if (v != coef_at(n, dual[i], k, j) || v != coef_at(n, k, dual[j], i)) begin
            r.st = ST_RECIP;
            return r;
          end
        end
    if (assoc_en)
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++)
          for (int k = 0; k < n; k++)
            for (int l = 0; l < n; l++) begin
              a = 0;
              b = 0;
              for (int s = 0; s < n; s++) begin
                a += longint'(coef_at(n, i, j, s)) * coef_at(n, s, k, l);
                b += longint'(coef_at(n, j, k, s)) * coef_at(n, i, s, l);
              end
              if (a[47:0] != b[47:0]) begin
                r = '{ST_ASSOC, i, j, k, l};
                return r;
              end
            end
    return r;
  endfunction

  always @(posedge clk_i) begin
    coeff_item_t it;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        it = pend_q.pop_front();
        if (loaded_cnt == 0) tensor_rank = it.rank;
        if (loaded_cnt < STORE_D) tensor_mem[loaded_cnt] = it.coeff;
        if (loaded_cnt < 65535) loaded_cnt++;
        if (it.last) begin
          verdict_q.insert(verdict_q.size(), judge_tensor());
          loaded_cnt = 0;
        end
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else if (!quiet && $urandom_range(0, 19) == 0) begin
          tx_gap = $urandom_range(0, 17);
          s_axis_tvalid_i <= 1'b0;
        end else if (pend_q.size() > 0) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i <= {6'd0, pend_q[0].rank, pend_q[0].coeff};
          s_axis_tlast_i <= pend_q[0].last;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && cycles > 3000) begin
        hold_done = 1'b1;
        hold_left = 30000;
      end
    end
  end

  always @(posedge clk_i) begin
    verdict_t e;
    bit [4:0] got [4];
    bit [4:0] want [4];
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL fusion_ring_axiom_checker");
      $finish;
    end
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $time, m_axis_tdata_o);
          errors++;
        end else begin
          e = verdict_q.pop_front();
          status_seen[e.st]++;
          if (m_axis_tdata_o[2:0] != e.st) begin
            $display("%0t: status expected %0d actual %0d", $time, e.st, m_axis_tdata_o[2:0]);
            errors++;
          end
          want = '{e.fi, e.fj, e.fk, e.fl};
          got = '{m_axis_tdata_o[7:3], m_axis_tdata_o[12:8], m_axis_tdata_o[17:13],
                  m_axis_tdata_o[22:18]};
          for (int f = 0; f < 4; f++)
            if (got[f] != want[f]) begin
              $display("%0t: fail index %0d expected %0d actual %0d", $time, f, want[f],
                       got[f]);
              errors++;
            end
        end
      end
      if (hold_left > 0) begin
        m_axis_tready_i <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        rx_gap = $urandom_range(0, 17);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  function automatic bit [19:0] ring_coef(int kind, int n, int i, int j, int k);
    case (kind)
      0: return (k == (i + j) % n) ? 20'd1 : 20'd0;
      1: return (i == 0) ? (j == k) : (j == 0) ? (i == k) : 20'd1;
      2: begin
        if (i == 0) return j == k;
        if (j == 0) return i == k;
        if (i == 2 && j == 2) return k != 2;
        if (i == 1 && j == 1) return k == 0;
        return k == 2;
      end
      default: return (k == (i ^ j)) ? 20'd1 : 20'd0;
    endcase
  endfunction

  task automatic queue_tensor(int n, int kind, int mutations, int count_delta);
    bit [19:0] t [$];
    coeff_item_t it;
    int total, idx;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        for (int k = 0; k < n; k++)
          t.insert(t.size(), ring_coef(kind, n, i, j, k));
    for (int m = 0; m < mutations; m++) begin
      idx = $urandom_range(0, t.size() - 1);
      case ($urandom_range(0, 2))
        0: t[idx] = t[idx] ^ 20'd1;
        1: t[idx] = $urandom_range(0, 3);
        default: t[idx] = $urandom();
      endcase
    end
    total = t.size() + count_delta;
    if (total < 1) total = 1;
    for (int x = 0; x < total; x++) begin
      it.coeff = (x < t.size()) ? t[x] : 20'($urandom());
      it.rank = (x == 0) ? 6'(n) : 6'($urandom());
      it.last = (x == total - 1);
      pend_q.insert(pend_q.size(), it);
    end
    tensors_sent++;
  endtask

  task automatic queue_raw(bit [5:0] rank, int total, bit [19:0] fill);
    coeff_item_t it;
    for (int x = 0; x < total; x++) begin
      it = '{fill, (x == 0) ? rank : 6'($urandom()), x == total - 1};
      pend_q.insert(pend_q.size(), it);
    end
    tensors_sent++;
  endtask

  task automatic drain_and_config(bit val);
    wait (pend_q.size() == 0 && verdict_q.size() == 0);
    repeat (20) @(posedge clk_i);
    cfg_wr_en_i <= 1'b1;
    cfg_wr_data_i <= val;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    assoc_en = val;
  endtask

  task automatic random_tensors(int items);
    int start, kind, n;
    start = 0;
    while (start < items) begin
      kind = $urandom_range(0, 3);
      n = (kind == 1) ? 2 : (kind == 2) ? 3 : (kind == 3) ? 4 : $urandom_range(1, 4);
      if (kind == 0 && $urandom_range(0, 15) == 0) n = 5;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: queue_tensor(n, kind, 0, 0);
        4, 5, 6: queue_tensor(n, kind, $urandom_range(1, 2), 0);
        7: queue_tensor(n, kind, 0, $urandom_range(0, 1) ? 1 : -1);
        8: queue_raw($urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(33, 63)),
                     $urandom_range(1, 4), 20'($urandom()));
        default: queue_tensor(n, kind, $urandom_range(0, 1), -$urandom_range(2, 5));
      endcase
      start += n * n * n;
    end
  endtask

  initial begin
    for (int s = 0; s < 8; s++) status_seen[s] = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    queue_raw(6'd0, 1, 20'hFFFFF);
    queue_raw(6'd63, 2, 20'd0);
    queue_raw(6'd1, 1, 20'hFFFFF);
    queue_raw(6'd1, 1, 20'd1);
    queue_tensor(2, 1, 0, 0);
    queue_raw(6'd32, 3, 20'd1);
    queue_tensor(3, 2, 0, 0);
    drain_and_config(1'b0);
    queue_tensor(2, 1, 0, 0);
    random_tensors(700);
    drain_and_config(1'b1);
    queue_raw(6'd32, 40, 20'd0);
    random_tensors(700);
    drain_and_config(1'b0);
    drain_and_config(1'b1);
    quiet = 1'b1;
    random_tensors(400);
    wait (pend_q.size() == 0 && verdict_q.size() == 0);
    repeat (50) @(posedge clk_i);
    $display("Sent %0d tensors: ranks 0 to 63, coefficient extremes, short and long loads.",
             tensors_sent);
    $display("Status counts ok/unit/dual/miss/invol/recip/assoc/count: %0d %0d %0d %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    $display("  %0d %0d %0d %0d", status_seen[4], status_seen[5], status_seen[6],
             status_seen[7]);
    if (errors == 0) begin
      $display("PASS fusion_ring_axiom_checker");
    end else begin
      $display("FAIL fusion_ring_axiom_checker");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/frac_pkg.sv
rtl/core/frac_ram.sv
rtl/core/frac_mac.sv
rtl/core/fusion_ring_axiom_checker.sv
tb/sv/fusion_ring_axiom_checker_tb.sv
